// File: rtl/stel_pkg.sv
// stel_pkg: widths, result status codes and the fixed-point helper of the
// signal-traded equity line. No dependencies; used by the channel
// interfaces and by the top level.
package stel_pkg;

	localparam int PRICE_W    = 32;              // Q16.16 prices and initial value
	localparam int PRICE_FRAC = 16;
	localparam int DATE_W     = 32;
	localparam int PROD_W     = 48;              // Q16.32 growth product, Q32.16 equity
	localparam int FRAC_W     = 32;              // fraction bits of the growth product
	localparam int DIGIT_W    = 2;               // bits handled per cycle
	localparam int STEPS      = PROD_W / DIGIT_W;
	localparam int CNT_W      = $clog2(STEPS);
	localparam int ACC_W      = PROD_W + DIGIT_W;
	localparam int STATUS_W   = 2;

	localparam logic [PROD_W-1:0]  PROD_ONE   = {{(PROD_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};
	localparam logic [PRICE_W-1:0] INIT_RESET = 32'd6553600;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INV_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ALT_MISS = 2'd2;

	typedef logic [PROD_W-1:0] prod_t;

	// full product is {acc, low}; return it shifted right by FRAC_W, saturated
	function automatic prod_t shr_sat(input logic [ACC_W-1:0] acc, input prod_t low);
		prod_t r;
		if (acc[ACC_W-1:FRAC_W] != '0)
			r = '1;
		else
			r = {acc[FRAC_W-1:0], low[PROD_W-1 -: (PROD_W-FRAC_W)]};
		return r;
	endfunction

endpackage

// File: rtl/stel_in_if.sv
// stel_in_if: observation channel, one dated observation per request.
// Depends on stel_pkg for field widths.
interface stel_in_if import stel_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DATE_W-1:0]  date;
	logic               inv_valid;
	logic [PRICE_W-1:0] inv_price;
	logic               alt_valid;
	logic [PRICE_W-1:0] alt_price;
	logic               sig_valid;
	logic               sig_negative;

	modport source (output valid, date, inv_valid, inv_price, alt_valid, alt_price,
		sig_valid, sig_negative, input ready);
	modport sink (input valid, date, inv_valid, inv_price, alt_valid, alt_price,
		sig_valid, sig_negative, output ready);
endinterface

// File: rtl/stel_out_if.sv
// stel_out_if: result channel, date, equity and status per request.
// Depends on stel_pkg for field widths.
interface stel_out_if import stel_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DATE_W-1:0]   out_date;
	logic [PROD_W-1:0]   equity;
	logic [STATUS_W-1:0] status;

	modport source (output valid, out_date, equity, status, input ready);
	modport sink (input valid, out_date, equity, status, output ready);
endinterface

// File: rtl/stel_cfg_if.sv
// stel_cfg_if: configuration write channel for the initial value register.
// Depends on stel_pkg for the register width.
interface stel_cfg_if import stel_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] start_value;

	modport source (output valid, start_value, input ready);
	modport sink (input valid, start_value, output ready);
endinterface

// File: rtl/signal_traded_equity_line_top.sv
// signal_traded_equity_line_top: equity curve of a signal-traded position.
// Depends on stel_pkg, stel_in_if, stel_out_if and stel_cfg_if.
//
// Usage:
//   obs    - one dated observation per request (both prices with valid bits,
//            optional buy/sell signal). ready is high only while the core is idle.
//   result - out_date, equity (Q32.16) and status, held in an output register.
//   cfg    - write of the starting funds (Q16.16), always ready; write it only when idle.
// Steps from accepted request to result valid:
//   when a price ratio is taken, the divide, the growth multiply, the product update,
//   the load and the equity multiply (two bits per cycle each); when the ratio
//   saturates, the same without the divide; when the change is 1, the load and the
//   equity multiply only. A signal on a date missing a price goes straight to the done
//   state. Observations missing a price without a signal give no result.
// One observation is in work at a time; the next request is taken the cycle after the
//   result is moved into the output register.
// A stalled receiver holds the output register; a finished result waits in the
//   core until the register frees. Reset sets product 1.0, prices 0, position buy,
//   no signal seen and initial value 100.0.
module signal_traded_equity_line_top import stel_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	stel_in_if.sink     obs,
	stel_out_if.source  result,
	stel_cfg_if.sink    cfg
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_MUL1 = 3'd2;
	localparam logic [2:0] S_PREP = 3'd3;
	localparam logic [2:0] S_LOAD = 3'd4;
	localparam logic [2:0] S_MUL2 = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PRICE_W-1:0]  init_q;
	prod_t               product_q;
	logic [PRICE_W-1:0]  prev_inv_q;
	logic [PRICE_W-1:0]  prev_alt_q;
	logic                hold_q;
	logic                seen_q;
	logic [DATE_W-1:0]   date_q;
	logic [STATUS_W-1:0] status_q;
	logic [PRICE_W-1:0]  rem_q;
	logic [PRICE_W-1:0]  den_q;
	logic [PRICE_FRAC-1:0] num_q;
	prod_t               mb_q;
	logic [ACC_W-1:0]    acc_q;
	prod_t               low_q;
	logic [ACC_W-1:0]    p3_q;
	logic                out_valid_q;
	logic [DATE_W-1:0]   out_date_q;
	prod_t               out_equity_q;
	logic [STATUS_W-1:0] out_status_q;

	logic               accept;
	logic               have_both;
	logic [PRICE_W-1:0] held_price;
	logic [PRICE_W-1:0] held_prev;
	logic               do_div;
	logic               div_sat;
	logic               last_step;
	logic               out_load;
	logic [PRICE_W:0]   t1, r1, t2, r2;
	logic               ge1, ge2;
	logic [ACC_W-1:0]   addend;
	logic [ACC_W-1:0]   sum;
	prod_t              shifted;

	assign obs.ready     = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign accept        = obs.valid && obs.ready;
	assign have_both     = obs.inv_valid && obs.alt_valid;
	assign held_price    = hold_q ? obs.inv_price : obs.alt_price;
	assign held_prev     = hold_q ? prev_inv_q : prev_alt_q;
	assign do_div        = seen_q && (held_prev != '0);
	// quotient reaches 2^48 exactly when price >= prev * 2^16
	assign div_sat       = (held_prev[PRICE_W-1:PRICE_FRAC] == '0)
		&& (held_price >= {held_prev[PRICE_FRAC-1:0], {PRICE_FRAC{1'b0}}});
	assign last_step     = (cnt_q == CNT_W'(STEPS-1));
	assign out_load      = (state_q == S_DONE) && (!out_valid_q || result.ready);
	assign shifted       = shr_sat(acc_q, low_q);

	// two restoring division steps per cycle
	always_comb begin
		t1  = {rem_q, num_q[PRICE_FRAC-1]};
		ge1 = (t1 >= {1'b0, den_q});
		r1  = ge1 ? (t1 - {1'b0, den_q}) : t1;
		t2  = {r1[PRICE_W-1:0], num_q[PRICE_FRAC-2]};
		ge2 = (t2 >= {1'b0, den_q});
		r2  = ge2 ? (t2 - {1'b0, den_q}) : t2;
	end

	// radix-4 shift-add multiply, multiplier digits taken lsb first
	always_comb begin
		case (mb_q[DIGIT_W-1:0])
			2'd0:    addend = '0;
			2'd1:    addend = {{DIGIT_W{1'b0}}, product_q};
			2'd2:    addend = {1'b0, product_q, 1'b0};
			default: addend = p3_q;
		endcase
		sum = acc_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			init_q      <= INIT_RESET;
			product_q   <= PROD_ONE;
			prev_inv_q  <= '0;
			prev_alt_q  <= '0;
			hold_q      <= 1'b1;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid)
				init_q <= cfg.start_value;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (!have_both) begin
							if (obs.sig_valid)
								state_q <= S_DONE;
						end else begin
							prev_inv_q <= obs.inv_price;
							prev_alt_q <= obs.alt_price;
							if (obs.sig_valid) begin
								hold_q <= !obs.sig_negative;
								seen_q <= 1'b1;
							end
							if (!do_div)
								state_q <= S_LOAD;
							else if (div_sat)
								state_q <= S_MUL1;
							else
								state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (last_step) begin
						cnt_q   <= '0;
						state_q <= S_MUL1;
					end else
						cnt_q <= cnt_q + 1'b1;
				end
				S_MUL1: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step)
						state_q <= S_PREP;
				end
				S_PREP: begin
					product_q <= shifted;
					state_q   <= S_LOAD;
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p3_q <= {{DIGIT_W{1'b0}}, product_q} + {1'b0, product_q, 1'b0};
		if (out_load) begin
			out_date_q   <= date_q;
			out_equity_q <= (status_q == ST_OK) ? shifted : '0;
			out_status_q <= status_q;
		end
		unique case (state_q) inside
			S_IDLE: begin
				if (accept) begin
					date_q <= obs.date;
					acc_q  <= '0;
					if (!have_both)
						status_q <= obs.inv_valid ? ST_ALT_MISS : ST_INV_MISS;
					else
						status_q <= ST_OK;
					if (div_sat)
						mb_q <= '1;
					rem_q <= {{(PRICE_W-PRICE_FRAC){1'b0}}, held_price[PRICE_W-1:PRICE_FRAC]};
					num_q <= held_price[PRICE_FRAC-1:0];
					den_q <= held_prev;
				end
			end
			S_DIV: begin
				rem_q <= r2[PRICE_W-1:0];
				num_q <= {num_q[PRICE_FRAC-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
				mb_q  <= {mb_q[PROD_W-DIGIT_W-1:0], ge1, ge2};
			end
			S_MUL1, S_MUL2: begin
				acc_q <= {{DIGIT_W{1'b0}}, sum[ACC_W-1:DIGIT_W]};
				low_q <= {sum[DIGIT_W-1:0], low_q[PROD_W-1:DIGIT_W]};
				mb_q  <= {{DIGIT_W{1'b0}}, mb_q[PROD_W-1:DIGIT_W]};
			end
			S_LOAD: begin
				acc_q <= '0;
				mb_q  <= {{(PROD_W-PRICE_W){1'b0}}, init_q};
			end
			default: ;
		endcase
	end

	assign result.valid    = out_valid_q;
	assign result.out_date = out_date_q;
	assign result.equity   = out_equity_q;
	assign result.status   = out_status_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != ST_OK)) |-> (out_equity_q == '0))
		else $error("error result carries nonzero equity");

	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(seen_q))
		else $error("signal seen flag cleared");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && (state_q == S_IDLE)))
		else $error("finished result not moved to output register");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV) || (state_q == S_MUL1) || (state_q == S_MUL2))
		|-> (cnt_q <= CNT_W'(STEPS-1)))
		else $error("digit counter out of range");

	a_product_change: assert property (@(posedge clk) disable iff (!arst_n)
		(product_q != $past(product_q)) |-> ($past(state_q) == S_PREP))
		else $error("growth product changed outside update");

endmodule

// File: tb/tb_signal_traded_equity_line_top.sv
// tb_signal_traded_equity_line_top: self-checking bench for the signal-traded equity line,
// with its own fixed-point predictor of the equity curve, bursty requests and a stalling sink.
// Depends on stel_pkg, stel_in_if, stel_out_if, stel_cfg_if and signal_traded_equity_line_top.
module tb_signal_traded_equity_line_top;
	timeunit 1ns;
	timeprecision 1ps;
	import stel_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 100;

	typedef struct packed {
		logic [DATE_W-1:0]  date;
		logic               inv_valid;
		logic [PRICE_W-1:0] inv_price;
		logic               alt_valid;
		logic [PRICE_W-1:0] alt_price;
		logic               sig_valid;
		logic               sig_negative;
	} obs_t;

	typedef struct packed {
		logic [DATE_W-1:0]   date;
		prod_t               equity;
		logic [STATUS_W-1:0] status;
	} res_t;

	class equity_checker;
		logic [PRICE_W-1:0] init_val;
		prod_t              growth;
		logic [PRICE_W-1:0] last_inv;
		logic [PRICE_W-1:0] last_alt;
		bit                 holding_inv;
		bit                 seen_signal;
		res_t               due_results[$];
		int                 errors;

		function new();
			init_val    = INIT_RESET;
			growth      = PROD_ONE;
			last_inv    = '0;
			last_alt    = '0;
			holding_inv = 1'b1;
			seen_signal = 1'b0;
			errors      = 0;
		endfunction

		function void set_initial(logic [PRICE_W-1:0] v);
			init_val = v;
		endfunction

		// (a * b) >> FRAC_W, saturated to the product width
		function prod_t mul_frac(prod_t a, prod_t b);
			logic [2*PROD_W-1:0] p;
			p = {{PROD_W{1'b0}}, a} * {{PROD_W{1'b0}}, b};
			if (p[2*PROD_W-1:PROD_W+FRAC_W] != '0)
				return '1;
			return p[PROD_W+FRAC_W-1:FRAC_W];
		endfunction

		function prod_t price_ratio(logic [PRICE_W-1:0] num, logic [PRICE_W-1:0] den);
			logic [PRICE_W+FRAC_W-1:0] q;
			q = {num, {FRAC_W{1'b0}}} / {{FRAC_W{1'b0}}, den};
			if (q[PRICE_W+FRAC_W-1:PROD_W] != '0)
				return '1;
			return q[PROD_W-1:0];
		endfunction

		function void take_observation(obs_t o);
			prod_t change;
			res_t  r;
			r.date = o.date;
			if (!o.inv_valid || !o.alt_valid) begin
				if (!o.sig_valid)
					return;
				r.equity = '0;
				r.status = o.inv_valid ? ST_ALT_MISS : ST_INV_MISS;
				due_results.push_back(r);
				return;
			end
			change = PROD_ONE;
			// the first signal date itself still counts as no change
			if (seen_signal) begin
				if (holding_inv && last_inv != '0)
					change = price_ratio(o.inv_price, last_inv);
				else if (!holding_inv && last_alt != '0)
					change = price_ratio(o.alt_price, last_alt);
			end
			last_inv = o.inv_price;
			last_alt = o.alt_price;
			growth   = mul_frac(growth, change);
			if (o.sig_valid) begin
				holding_inv = !o.sig_negative;
				seen_signal = 1'b1;
			end
			r.equity = mul_frac(growth, {{(PROD_W-PRICE_W){1'b0}}, init_val});
			r.status = ST_OK;
			due_results.push_back(r);
		endfunction

		function void match_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got date %h equity %h status %0d",
					$time, got.date, got.equity, got.status);
				return;
			end
			want = due_results.pop_front();
			if (got.date !== want.date) begin
				errors++;
				$display("%0t: out_date mismatch, expected %h got %h", $time, want.date, got.date);
			end
			if (got.equity !== want.equity) begin
				errors++;
				$display("%0t: equity mismatch (date %h), expected %h got %h",
					$time, want.date, want.equity, got.equity);
			end
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status mismatch (date %h), expected %0d got %0d",
					$time, want.date, want.status, got.status);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	stel_in_if  obs();
	stel_out_if result();
	stel_cfg_if cfg();

	signal_traded_equity_line_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.obs    (obs),
		.result (result),
		.cfg    (cfg)
	);

	equity_checker curve = new();

	int                 burst_left;
	int                 quiet_cycles;
	int                 rx_mode;
	int                 rx_left;
	int                 rx_phase;
	logic [DATE_W-1:0]  date_ctr;
	logic [PRICE_W-1:0] lvl_inv;
	logic [PRICE_W-1:0] lvl_alt;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result sink with its own stall pattern
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			curve.match_result({result.out_date, result.equity, result.status});
		if (rx_left <= 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(50, 300);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			0: result.ready <= 1'b1;
			1: result.ready <= ($urandom_range(0, 3) != 0);
			2: result.ready <= ($urandom_range(0, 3) == 0);
			default: result.ready <= ((rx_phase % 32) >= 20);
		endcase
	end

	always @(posedge clk) begin
		if ((obs.valid && obs.ready) || (result.valid && result.ready) || (cfg.valid && cfg.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("signal_traded_equity_line_top regression: fail");
			$finish;
		end
	end

	function automatic obs_t mk_obs(logic [DATE_W-1:0] d, logic iv, logic [PRICE_W-1:0] ip,
		logic av, logic [PRICE_W-1:0] ap, logic sv, logic sn);
		return {d, iv, ip, av, ap, sv, sn};
	endfunction

	function automatic logic [PRICE_W-1:0] any_price();
		logic [PRICE_W-1:0] v;
		v = $urandom;
		if (v == '0)
			v = 1;
		return v;
	endfunction

	// random walk within an eighth of the current level
	function automatic logic [PRICE_W-1:0] step_level(logic [PRICE_W-1:0] lvl);
		longint span;
		longint p;
		span = longint'(lvl) >> 3;
		p = longint'(lvl) - span + longint'($urandom_range(0, 32'(2 * span)));
		if (p < 1)
			p = 1;
		if (p > 64'd4294967295)
			p = 64'd4294967295;
		return p[PRICE_W-1:0];
	endfunction

	task automatic send_obs(input obs_t o);
		int gap;
		obs.valid        <= 1'b1;
		obs.date         <= o.date;
		obs.inv_valid    <= o.inv_valid;
		obs.inv_price    <= o.inv_price;
		obs.alt_valid    <= o.alt_valid;
		obs.alt_price    <= o.alt_price;
		obs.sig_valid    <= o.sig_valid;
		obs.sig_negative <= o.sig_negative;
		@(posedge clk);
		while (obs.ready !== 1'b1)
			@(posedge clk);
		curve.take_observation(o);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
			if (gap > 0) begin
				obs.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop requests, let every result out, then give the core time to go idle
	task automatic drain_results();
		obs.valid <= 1'b0;
		while (curve.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_initial(input logic [PRICE_W-1:0] v);
		drain_results();
		cfg.valid       <= 1'b1;
		cfg.start_value <= v;
		@(posedge clk);
		while (cfg.ready !== 1'b1)
			@(posedge clk);
		cfg.valid <= 1'b0;
		curve.set_initial(v);
	endtask

	task automatic run_random(input int n_results);
		int   made;
		int   pick;
		obs_t o;
		made = 0;
		while (made < n_results) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 19) == 0)
				date_ctr = $urandom;
			else
				date_ctr = date_ctr + $urandom_range(1, 3);
			lvl_inv = step_level(lvl_inv);
			lvl_alt = step_level(lvl_alt);
			o = mk_obs(date_ctr, 1'b1, lvl_inv, 1'b1, lvl_alt, ($urandom_range(0, 7) == 0),
				1'($urandom_range(0, 1)));
			if (pick >= 95) begin
				// random price jump on each instrument, chosen independently
				if ($urandom_range(0, 1))
					lvl_inv = any_price();
				if ($urandom_range(0, 1))
					lvl_alt = any_price();
				o.inv_price = lvl_inv;
				o.alt_price = lvl_alt;
			end else if (pick >= 80) begin
				// missing price: an error result with a signal, dropped without one
				case ($urandom_range(0, 2))
					0: o.inv_valid = 1'b0;
					1: o.alt_valid = 1'b0;
					default: begin
						o.inv_valid = 1'b0;
						o.alt_valid = 1'b0;
					end
				endcase
				if (!o.inv_valid)
					o.inv_price = $urandom;
				if (!o.alt_valid)
					o.alt_price = $urandom;
				o.sig_valid = (pick < 90);
			end
			if ((o.inv_valid && o.alt_valid) || o.sig_valid)
				made++;
			send_obs(o);
		end
	endtask

	initial begin
		obs_t o;
		arst_n           = 1'b0;
		obs.valid        = 1'b0;
		obs.date         = '0;
		obs.inv_valid    = 1'b0;
		obs.inv_price    = '0;
		obs.alt_valid    = 1'b0;
		obs.alt_price    = '0;
		obs.sig_valid    = 1'b0;
		obs.sig_negative = 1'b0;
		cfg.valid        = 1'b0;
		cfg.start_value  = INIT_RESET;
		burst_left       = 1;
		date_ctr         = 32'd100;
		lvl_inv          = 32'h0064_0000;
		lvl_alt          = 32'h0032_0000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: drops, error codes, first signal, zero previous price, ratio extremes
		send_obs(mk_obs(32'd0, 1'b1, 32'h0001_0000, 1'b1, 32'h0002_0000, 1'b0, 1'b0));
		send_obs(mk_obs(32'd1, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 1'b0, 1'b1));
		send_obs(mk_obs(32'd2, 1'b1, 32'h0000_0001, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0));
		send_obs(mk_obs(32'd3, 1'b0, 32'h1234_5678, 1'b1, 32'h0001_0000, 1'b1, 1'b0));
		send_obs(mk_obs(32'd4, 1'b1, 32'h0001_0000, 1'b0, 32'h8765_4321, 1'b1, 1'b1));
		send_obs(mk_obs(32'd5, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0));
		send_obs(mk_obs(32'd6, 1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0));
		send_obs(mk_obs(32'd7, 1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b0));
		send_obs(mk_obs(32'd8, 1'b1, 32'h0002_0000, 1'b1, 32'h0003_0000, 1'b0, 1'b0));
		send_obs(mk_obs(32'd9, 1'b1, 32'h0003_0000, 1'b1, 32'h0004_0000, 1'b0, 1'b1));
		send_obs(mk_obs(32'd10, 1'b1, 32'h0003_8000, 1'b1, 32'h0001_0000, 1'b1, 1'b1));
		send_obs(mk_obs(32'd11, 1'b1, 32'h0001_0000, 1'b1, 32'h0000_0001, 1'b0, 1'b0));
		send_obs(mk_obs(32'd12, 1'b1, 32'h0002_0000, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0));
		send_obs(mk_obs(32'd13, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 1'b1, 1'b0));
		send_obs(mk_obs(32'd14, 1'b1, 32'h0000_0001, 1'b1, 32'h8000_0000, 1'b0, 1'b0));
		send_obs(mk_obs(32'd15, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0001_0000, 1'b0, 1'b1));
		send_obs(mk_obs(32'hFFFF_FFFF, 1'b1, 32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0, 1'b0));
		send_obs(mk_obs(32'hFFFF_FFFF, 1'b1, 32'h0001_0000, 1'b1, 32'h0001_0000, 1'b1, 1'b1));
		send_obs(mk_obs(32'h8000_0000, 1'b1, 32'h0002_0000, 1'b1, 32'h0002_0000, 1'b1, 1'b0));

		write_initial(32'hFFFF_FFFF);
		run_random(180);
		write_initial(32'h0000_0000);
		run_random(120);
		write_initial(32'h0000_0001);
		run_random(120);
		write_initial($urandom);
		run_random(240);
		write_initial(INIT_RESET);
		run_random(240);

		// held instrument drops to zero: product goes to zero and stays there
		o = mk_obs(date_ctr + 1, 1'b1, curve.holding_inv ? 32'h0 : any_price(), 1'b1,
			curve.holding_inv ? any_price() : 32'h0, 1'b0, 1'b0);
		send_obs(o);
		send_obs(mk_obs(date_ctr + 2, 1'b1, any_price(), 1'b1, any_price(), 1'b0, 1'b0));

		drain_results();
		if (curve.errors == 0 && curve.due_results.size() == 0)
			$display("signal_traded_equity_line_top regression: pass");
		else
			$display("signal_traded_equity_line_top regression: fail");
		$finish;
	end

endmodule

// File: signal_traded_equity_line_top.f
rtl/stel_pkg.sv
rtl/stel_in_if.sv
rtl/stel_out_if.sv
rtl/stel_cfg_if.sv
rtl/signal_traded_equity_line_top.sv
tb/tb_signal_traded_equity_line_top.sv
